FILE: src/orm_pkg.sv
// Shared types and constants for the offset remap table.
package orm_pkg;

   localparam int TABLE_DEPTH = 128;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int POS_W       = 32;
   localparam int SHIFT_W     = POS_W + 1;
   localparam int MAP_W       = POS_W + 2;

   typedef struct packed {
      logic             action;
      logic [POS_W-1:0] old_pos;
      logic [POS_W-1:0] new_pos;
   } req_type;

   typedef struct packed {
      logic signed [MAP_W-1:0] mapped_pos;
      logic                    appended;
      logic                    table_full;
   } rsp_type;

   localparam logic ACT_CHECK = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef struct packed {
      logic start;
      logic scan;
      logic calc;
      logic finish;
   } orm_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } orm_stat_type;

endpackage

FILE: src/orm_ctrl.sv
// Sequencer for the offset remap table: accept, scan, compute, write back.
module orm_ctrl
   import orm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  orm_stat_type stat,
   output orm_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_CALC = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready  = (state_ff == ST_IDLE);
   assign cmd.start  = req_valid && req_ready;
   assign cmd.scan   = (state_ff == ST_SCAN);
   assign cmd.calc   = (state_ff == ST_CALC);
   assign cmd.finish = (state_ff == ST_DONE) && stat.out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.scan_done) state_in = ST_CALC;
         end
         ST_CALC: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the result register can take the transfer
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/orm_datapath.sv
// Breakpoint memory, scan pipeline, position arithmetic and result register.
module orm_datapath
   import orm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  req_type      req_data,
   input  orm_cmd_type  cmd,
   output orm_stat_type stat,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   // entry 0 is never stored: it is always {0,0} and seeds the governing shift
   logic [POS_W+SHIFT_W-1:0] mem [TABLE_DEPTH];

   req_type                  item_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         issue_ff;
   logic                     rd_vld_ff;
   logic [POS_W+SHIFT_W-1:0] rd_data_ff;
   logic                     stop_ff;
   logic [SHIFT_W-1:0]       gov_ff;
   logic [MAP_W-1:0]         mapped_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;

   logic               issue_more;
   logic [POS_W-1:0]   rd_old;
   logic [SHIFT_W-1:0] rd_shift;
   logic               mismatch;
   logic               room;
   logic [SHIFT_W-1:0] new_shift;

   assign issue_more = (issue_ff != count_ff);
   assign rd_old     = rd_data_ff[POS_W+SHIFT_W-1:SHIFT_W];
   assign rd_shift   = rd_data_ff[SHIFT_W-1:0];
   assign mismatch   = (item_ff.action == ACT_CHECK) &&
                       (mapped_ff != {2'b00, item_ff.new_pos});
   assign room       = (count_ff != CNT_W'(TABLE_DEPTH));
   assign new_shift  = {1'b0, item_ff.new_pos} - {1'b0, item_ff.old_pos};

   assign stat.scan_done = stop_ff || (!issue_more && !rd_vld_ff);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.scan && issue_more) begin
         rd_data_ff <= mem[issue_ff[IDX_W-1:0]];
      end
      if (cmd.finish && mismatch && room) begin
         mem[count_ff[IDX_W-1:0]] <= {item_ff.old_pos, new_shift};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         item_ff <= req_data;
      end
      if (cmd.start) begin
         gov_ff <= '0;
      end else if (cmd.scan && rd_vld_ff && !stop_ff && !(rd_old > item_ff.old_pos)) begin
         gov_ff <= rd_shift;
      end
      if (cmd.calc) begin
         mapped_ff <= {2'b00, item_ff.old_pos} + {gov_ff[SHIFT_W-1], gov_ff};
      end
      if (cmd.finish) begin
         rsp_ff.mapped_pos <= mapped_ff;
         rsp_ff.appended   <= mismatch && room;
         rsp_ff.table_full <= mismatch && !room;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CNT_W'(1);
         issue_ff     <= CNT_W'(1);
         rd_vld_ff    <= 1'b0;
         stop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.start) begin
            issue_ff <= CNT_W'(1);
            stop_ff  <= 1'b0;
         end else if (cmd.scan) begin
            if (issue_more) issue_ff <= issue_ff + CNT_W'(1);
            // drop everything after the first entry above the position
            if (rd_vld_ff && (rd_old > item_ff.old_pos)) stop_ff <= 1'b1;
         end
         rd_vld_ff <= cmd.scan && issue_more;
         if (cmd.finish && mismatch && room) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

FILE: src/offset_remap_table_unit.sv
// Offset remap table top level: breakpoint lookup and append.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_data  (action, old_pos, new_pos)
//   rsp      out        rsp_valid/rsp_ready  rsp_data  (mapped_pos, appended, table_full)
//
// After the request transfer the scan reads one breakpoint per cycle from the
// single-port memory, stopping early after the first entry above old_pos, and
// then drains the last read; then the shift is added, and once the result register
// is free the append is written back and the result register loaded in the same cycle.
// A new item is taken while the previous result waits; its result holds back
// until that one is transferred. Reset leaves one entry {0,0}; no clearing pass runs.
module offset_remap_table_unit
   import orm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   orm_cmd_type  cmd;
   orm_stat_type stat;

   orm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   orm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: src/orm_checker.sv
// Port-level checks for the offset remap table, bound to the top level.
module orm_checker
   import orm_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.appended && rsp_data.table_full))
      else $error("appended and table_full both set");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken during a scan");

   a_query_only: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.action == ACT_QUERY) |=> !rsp_valid || rsp_ready ||
      !rsp_data.appended || $stable(rsp_data))
      else $error("query transfer disturbed a pending result");

endmodule

bind offset_remap_table_unit orm_checker u_orm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
